@@ rtl/gsmsi1_pkg.sv @@
package gsmsi1_pkg;

  // Message layout
  localparam int MESSAGE_BYTES_DEF = 23;
  localparam int BITMAP_BYTES      = 16;
  localparam int POS_W             = 5;
  localparam logic [POS_W-1:0] CCD_FIRST = 5'd3;
  localparam logic [POS_W-1:0] RACH_POS  = POS_W'(CCD_FIRST + BITMAP_BYTES);
  localparam logic [7:0] SI1_TYPE   = 8'h19;
  localparam logic [7:0] MAX_ARFCN  = 8'd124;

  // Cell channel description format codes
  localparam logic [7:0] FMT_BITMAP0  = 8'd0;
  localparam logic [7:0] FMT_VARIABLE = 8'd1;
  localparam logic [7:0] FMT_R128     = 8'd7;
  localparam logic [7:0] FMT_R256     = 8'd8;
  localparam logic [7:0] FMT_R512     = 8'd9;
  localparam logic [7:0] FMT_R1024    = 8'd10;
  localparam logic [7:0] FMT_RESERVED = 8'd15;

  typedef enum logic [2:0] {
    KIND_LENGTH    = 3'd0,
    KIND_DISCRIM   = 3'd1,
    KIND_MSG_TYPE  = 3'd2,
    KIND_FORMAT    = 3'd3,
    KIND_ARFCN     = 3'd4,
    KIND_RACH      = 3'd5,
    KIND_EMERGENCY = 3'd6
  } kind_t;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       start_of_message;
  } msg_req_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic [3:0] skip_indicator;
    logic [2:0] max_retrans;
    logic [5:0] tx_integer;
    logic       cell_barred;
    logic       reestablish_not_allowed;
    logic       emergency_restricted;
    logic       last_of_byte;
  } res_req_t;

  // Format ID from the first description byte
  function automatic logic [7:0] classify(input logic [7:0] b);
    logic [7:0] f;
    if (b[7:6] == 2'b00) begin
      f = FMT_BITMAP0;
    end else if (b[7:6] != 2'b10) begin
      f = FMT_RESERVED;
    end else if (!b[3]) begin
      f = FMT_R1024;
    end else begin
      case (b[2:1])
        2'd0:    f = FMT_R512;
        2'd1:    f = FMT_R256;
        2'd2:    f = FMT_R128;
        default: f = FMT_VARIABLE;
      endcase
    end
    return f;
  endfunction

  function automatic logic [2:0] retrans_lookup(input logic [1:0] code);
    logic [2:0] r;
    case (code)
      2'd0:    r = 3'd1;
      2'd1:    r = 3'd2;
      2'd2:    r = 3'd4;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] tx_lookup(input logic [3:0] code);
    logic [5:0] t;
    case (code)
      4'd0:    t = 6'd3;
      4'd1:    t = 6'd4;
      4'd2:    t = 6'd5;
      4'd3:    t = 6'd6;
      4'd4:    t = 6'd7;
      4'd5:    t = 6'd8;
      4'd6:    t = 6'd9;
      4'd7:    t = 6'd10;
      4'd8:    t = 6'd11;
      4'd9:    t = 6'd12;
      4'd10:   t = 6'd14;
      4'd11:   t = 6'd16;
      4'd12:   t = 6'd20;
      4'd13:   t = 6'd25;
      4'd14:   t = 6'd32;
      default: t = 6'd50;
    endcase
    return t;
  endfunction

endpackage

@@ rtl/gsm_si1_cell_channel_parser_core.sv @@
// Accepted bytes go to the hold stage, their results then to the result register.
// Throughput: one result per cycle while res_stall is low; a byte causing n results
// holds the input until its last leaves the hold stage, up to eight for a bitmap byte.
// Reset (rst, synchronous): byte position to 0, type and format flags clear,
// hold and result stages emptied.
module gsm_si1_cell_channel_parser_core
  import gsmsi1_pkg::*;
#(
  parameter int MESSAGE_BYTES = MESSAGE_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     msg_valid,
  output logic     msg_stall,
  input  msg_req_t msg_req,
  output logic     res_valid,
  input  logic     res_stall,
  output res_req_t res_req
);

  // Parser state, advanced once per accepted byte
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic             type_one_seen, type_one_seen_next;
  logic             bitmap_zero_format, bitmap_zero_format_next;

  // Decode of the incoming byte
  logic [POS_W-1:0] pos;
  logic [POS_W:0]   pos_inc;
  logic [3:0]       bm_idx;
  logic [7:0]       b;
  logic             hdr_new;
  res_req_t         hdr_res_new;
  logic [7:0]       mask_new;
  logic [7:0]       base_new;
  logic             accept;

  // Hold stage: one byte's results awaiting serialisation
  logic             h_valid;
  logic             h_hdr;
  res_req_t         h_res;
  logic [7:0]       h_mask;
  logic [7:0]       h_base;

  // Emission
  logic             emit;
  logic             emit_last;
  logic [2:0]       bit_idx;
  logic [7:0]       rem_mask;
  res_req_t         emit_res;

  assign accept = msg_valid && !msg_stall;

  always_comb begin
    b        = msg_req.msg_byte;
    pos      = msg_req.start_of_message ? '0 : byte_position;
    bm_idx   = 4'(pos - CCD_FIRST);
    base_new = {1'b0, 4'(4'(BITMAP_BYTES - 1) - bm_idx), 3'b000} + 8'd1;

    hdr_new                 = 1'b0;
    hdr_res_new             = '0;
    mask_new                = '0;
    type_one_seen_next      = type_one_seen;
    bitmap_zero_format_next = bitmap_zero_format;

    if (pos == POS_W'(0)) begin
      hdr_new           = 1'b1;
      hdr_res_new.kind  = KIND_LENGTH;
      hdr_res_new.value = b;
    end else if (pos == POS_W'(1)) begin
      hdr_new                    = 1'b1;
      hdr_res_new.kind           = KIND_DISCRIM;
      hdr_res_new.value          = {4'd0, b[3:0]};
      hdr_res_new.skip_indicator = b[7:4];
    end else if (pos == POS_W'(2)) begin
      hdr_new                 = 1'b1;
      hdr_res_new.kind        = KIND_MSG_TYPE;
      hdr_res_new.value       = b;
      type_one_seen_next      = (b == SI1_TYPE);
      bitmap_zero_format_next = 1'b0;
    end else if (type_one_seen) begin
      if (pos >= CCD_FIRST && pos < RACH_POS) begin
        if (pos == CCD_FIRST) begin
          hdr_new                 = 1'b1;
          hdr_res_new.kind        = KIND_FORMAT;
          hdr_res_new.value       = classify(b);
          bitmap_zero_format_next = (classify(b) == FMT_BITMAP0);
        end
        // ARFCNs above 124 are spare bits and are dropped
        for (int j = 0; j < 8; j++) begin
          mask_new[j] = bitmap_zero_format_next && b[j] &&
                        ((base_new + 8'(j)) <= MAX_ARFCN);
        end
      end else if (pos == RACH_POS) begin
        hdr_new                             = 1'b1;
        hdr_res_new.kind                    = KIND_RACH;
        hdr_res_new.max_retrans             = retrans_lookup(b[7:6]);
        hdr_res_new.tx_integer              = tx_lookup(b[5:2]);
        hdr_res_new.cell_barred             = b[1];
        hdr_res_new.reestablish_not_allowed = b[0];
      end else if (pos == POS_W'(RACH_POS + POS_W'(1))) begin
        hdr_new                          = 1'b1;
        hdr_res_new.kind                 = KIND_EMERGENCY;
        hdr_res_new.emergency_restricted = b[2];
      end
    end

    // Wrap at end of message
    pos_inc            = {1'b0, pos} + (POS_W + 1)'(1);
    byte_position_next = (pos_inc >= (POS_W + 1)'(MESSAGE_BYTES)) ? '0 : pos_inc[POS_W-1:0];
  end

  // Lowest pending ARFCN bit; header result always goes first
  always_comb begin
    bit_idx = '0;
    for (int j = 7; j >= 0; j--) begin
      if (h_mask[j]) begin
        bit_idx = 3'(j);
      end
    end
    rem_mask          = h_mask;
    rem_mask[bit_idx] = 1'b0;

    emit      = h_valid && (!res_valid || !res_stall);
    emit_last = h_hdr ? (h_mask == '0) : (rem_mask == '0);

    if (h_hdr) begin
      emit_res = h_res;
    end else begin
      emit_res       = '0;
      emit_res.kind  = KIND_ARFCN;
      emit_res.value = h_base + {5'd0, bit_idx};
    end
    emit_res.last_of_byte = emit_last;
  end

  // Input waits while the hold stage is occupied, unless its final result leaves now
  assign msg_stall = h_valid && !(emit && emit_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      type_one_seen      <= 1'b0;
      bitmap_zero_format <= 1'b0;
    end else if (accept) begin
      byte_position      <= byte_position_next;
      type_one_seen      <= type_one_seen_next;
      bitmap_zero_format <= bitmap_zero_format_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
      h_hdr   <= 1'b0;
    end else if (accept) begin
      h_valid <= hdr_new || (mask_new != '0);
      h_hdr   <= hdr_new;
    end else if (emit) begin
      h_valid <= !emit_last;
      h_hdr   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      h_res  <= hdr_res_new;
      h_mask <= mask_new;
      h_base <= base_new;
    end else if (emit && !h_hdr) begin
      h_mask <= rem_mask;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_req <= emit_res;
    end
  end

  // Checks
  a_stall_only_busy : assert property (@(posedge clk) disable iff (rst)
    msg_stall |-> h_valid)
    else $error("input stalled with empty hold stage");

  a_hold_not_empty : assert property (@(posedge clk) disable iff (rst)
    h_valid |-> (h_hdr || h_mask != '0))
    else $error("hold stage valid with nothing to emit");

  a_last_drains : assert property (@(posedge clk) disable iff (rst)
    (emit && emit_last && !accept) |=> !h_valid)
    else $error("hold stage not cleared after final result");

  a_pos_range : assert property (@(posedge clk) disable iff (rst)
    (POS_W + 1)'(byte_position) < (POS_W + 1)'(MESSAGE_BYTES))
    else $error("byte position beyond message length");

endmodule

@@ tb/tb_gsm_si1_cell_channel_parser_core.sv @@
`timescale 1ns / 100ps

module tb_gsm_si1_cell_channel_parser_core;
  import gsmsi1_pkg::*;

  localparam int HOLD_CYCLES = 64;   // long receiver hold-off for the pressure test
  localparam int RANDOM_BYTES = 228;
  localparam int CALM_AFTER = 180;   // random bytes after which idling stops
  localparam int MAX_PRINTS = 30;

  logic     clk;
  logic     rst;
  logic     msg_valid;
  logic     msg_stall;
  msg_req_t msg_req;
  logic     res_valid;
  logic     res_stall;
  res_req_t res_req;

  // Predictor state: mirrors the parser's byte position and message flags
  logic [POS_W-1:0] parse_pos = '0;
  logic             si1_seen = 1'b0;
  logic             bitmap0_active = 1'b0;

  // Results still owed by the parser, oldest first
  res_req_t expected_results[$];

  int   bytes_sent = 0;
  int   results_checked = 0;
  int   mismatches = 0;
  int   si1_messages = 0;
  int   arfcn_results = 0;
  logic [15:0] formats_seen = '0;

  bit gaps_on = 1'b1;        // sender idle bursts
  bit stall_on = 1'b1;       // receiver stall bursts
  bit hold_off_req = 1'b0;   // ask the receiver for one long hold-off

  gsm_si1_cell_channel_parser_core uut (
    .clk      (clk),
    .rst      (rst),
    .msg_valid(msg_valid),
    .msg_stall(msg_stall),
    .msg_req  (msg_req),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_req  (res_req)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Generous fixed limit; a correct run needs a small fraction of this
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Works out every result one accepted byte causes and queues them.
  function automatic void predict_byte(input logic [7:0] b, input logic som);
    res_req_t batch[$];
    res_req_t r;
    logic [POS_W-1:0] pos;
    int arfcn;
    if (som) begin
      parse_pos = '0;
    end
    pos = parse_pos;
    r = '0;
    if (pos == 0) begin
      r.kind = KIND_LENGTH;
      r.value = b;
      batch.push_back(r);
    end else if (pos == 1) begin
      // discriminator in the low nibble, skip indicator in the high one
      r.kind = KIND_DISCRIM;
      r.value = {4'h0, b[3:0]};
      r.skip_indicator = b[7:4];
      batch.push_back(r);
    end else if (pos == 2) begin
      r.kind = KIND_MSG_TYPE;
      r.value = b;
      batch.push_back(r);
      si1_seen = (b == SI1_TYPE);
      bitmap0_active = 1'b0;
      if (si1_seen) begin
        si1_messages++;
      end
    end else if (si1_seen) begin
      if (pos < RACH_POS) begin
        if (pos == CCD_FIRST) begin
          // format ID: top two bits, then the range / variable bits
          r.kind = KIND_FORMAT;
          if (b[7:6] == 2'b00) begin
            r.value = FMT_BITMAP0;
          end else if (b[7:6] != 2'b10) begin
            r.value = FMT_RESERVED;
          end else if (!b[3]) begin
            r.value = FMT_R1024;
          end else begin
            case (b[2:1])
              2'd0: r.value = FMT_R512;
              2'd1: r.value = FMT_R256;
              2'd2: r.value = FMT_R128;
              default: r.value = FMT_VARIABLE;
            endcase
          end
          formats_seen[r.value[3:0]] = 1'b1;
          bitmap0_active = (r.value == FMT_BITMAP0);
          batch.push_back(r);
        end
        if (bitmap0_active) begin
          // first description byte carries the highest ARFCNs; above 124 is spare
          for (int j = 0; j < 8; j++) begin
            arfcn = (BITMAP_BYTES - 1 - (int'(pos) - int'(CCD_FIRST))) * 8 + j + 1;
            if (b[j] && arfcn <= int'(MAX_ARFCN)) begin
              r = '0;
              r.kind = KIND_ARFCN;
              r.value = 8'(arfcn);
              batch.push_back(r);
              arfcn_results++;
            end
          end
        end
      end else if (pos == RACH_POS) begin
        r.kind = KIND_RACH;
        r.max_retrans = (b[7:6] == 2'd3) ? 3'd7 : 3'(1 << b[7:6]);
        case (b[5:2])
          4'd10: r.tx_integer = 6'd14;
          4'd11: r.tx_integer = 6'd16;
          4'd12: r.tx_integer = 6'd20;
          4'd13: r.tx_integer = 6'd25;
          4'd14: r.tx_integer = 6'd32;
          4'd15: r.tx_integer = 6'd50;
          default: r.tx_integer = 6'(b[5:2]) + 6'd3;
        endcase
        r.cell_barred = b[1];
        r.reestablish_not_allowed = b[0];
        batch.push_back(r);
      end else if (pos == RACH_POS + 5'd1) begin
        r.kind = KIND_EMERGENCY;
        r.emergency_restricted = b[2];
        batch.push_back(r);
      end
    end
    if (batch.size() > 0) begin
      batch[batch.size() - 1].last_of_byte = 1'b1;
    end
    foreach (batch[i]) begin
      expected_results.push_back(batch[i]);
    end
    parse_pos = (int'(pos) == MESSAGE_BYTES_DEF - 1) ? '0 : pos + 5'd1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_PRINTS) begin
      $display("%0t: result %0d: %s got %0d, expected %0d",
               $time, results_checked, what, got, want);
    end
    mismatches++;
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) begin
      report_mismatch(what, got, want);
    end
  endtask

  // Offers one byte request, with an optional idle burst first, and returns
  // at the edge where it is taken. Valid is left high for the next caller.
  task automatic send_byte(input logic [7:0] b, input logic som);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      msg_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg_req <= '{msg_byte: b, start_of_message: som};
    do @(posedge clk); while (msg_stall);
    predict_byte(b, som);
    bytes_sent++;
  endtask

  // Receiver: random stall bursts, plus one long hold-off when asked
  initial begin
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_stall <= 1'b0;
        hold_off_req = 1'b0;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  // Result checker: every accepted result against the oldest expectation
  initial begin
    res_req_t want;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, kind", int'(res_req.kind), -1);
        end else begin
          want = expected_results.pop_front();
          check_field("kind", int'(res_req.kind), int'(want.kind));
          check_field("value", int'(res_req.value), int'(want.value));
          check_field("skip_indicator", int'(res_req.skip_indicator),
                      int'(want.skip_indicator));
          check_field("max_retrans", int'(res_req.max_retrans), int'(want.max_retrans));
          check_field("tx_integer", int'(res_req.tx_integer), int'(want.tx_integer));
          check_field("cell_barred", int'(res_req.cell_barred), int'(want.cell_barred));
          check_field("reestablish_not_allowed", int'(res_req.reestablish_not_allowed),
                      int'(want.reestablish_not_allowed));
          check_field("emergency_restricted", int'(res_req.emergency_restricted),
                      int'(want.emergency_restricted));
          check_field("last_of_byte", int'(res_req.last_of_byte), int'(want.last_of_byte));
        end
        results_checked++;
      end
    end
  end

  // Full SI1 message, bit map 0, every bit set but the format bits: eight ARFCNs per byte,
  // spare bits in the first description byte, all-ones RACH fields, and two
  // trailing bytes that give nothing.
  task automatic test_full_bitmap_message();
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(SI1_TYPE, 1'b0);
    send_byte(8'h3F, 1'b0);
    repeat (BITMAP_BYTES - 1) send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
  endtask

  // Starts without the flag, relying on the wrap after the last byte; a
  // non-SI1 type then silences the body, and the flag cuts the message short.
  task automatic test_other_message_type();
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h1A, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h12, 1'b1);
  endtask

  // Receiver holds off while a dense bit map 0 message is offered, so the
  // hold stage fills and the input request stalls. All-zero RACH fields.
  task automatic test_result_backpressure();
    hold_off_req = 1'b1;
    send_byte(8'h59, 1'b1);
    send_byte(8'h06, 1'b0);
    send_byte(SI1_TYPE, 1'b0);
    send_byte(8'h0F, 1'b0);
    repeat (BITMAP_BYTES - 1) send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b0);
  endtask

  // Mostly well-formed SI1 messages with random content; some other types,
  // some cut short by a new start flag, some relying on the wrap.
  task automatic test_random_messages();
    int sent;
    int len;
    int density;
    logic [7:0] b;
    logic [7:0] msg_type;
    logic [7:0] ccd_first;
    logic first_flag;
    logic prev_full;
    sent = 0;
    prev_full = 1'b1;
    while (sent < RANDOM_BYTES) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, MESSAGE_BYTES_DEF - 1)
                                        : MESSAGE_BYTES_DEF;
      first_flag = !(prev_full && $urandom_range(0, 2) == 0);
      msg_type = ($urandom_range(0, 3) == 0) ? 8'($urandom) : SI1_TYPE;
      case ($urandom_range(0, 3))
        0, 1: ccd_first = {2'b00, 6'($urandom)};
        2: ccd_first = {2'b10, 6'($urandom)};
        default: ccd_first = 8'($urandom);
      endcase
      density = $urandom_range(0, 2);
      for (int k = 0; k < len; k++) begin
        if (sent >= CALM_AFTER) begin
          gaps_on = 1'b0;
          stall_on = 1'b0;
        end
        if (k == 2) begin
          b = msg_type;
        end else if (k == int'(CCD_FIRST)) begin
          b = ccd_first;
        end else if (k > int'(CCD_FIRST) && k < int'(RACH_POS)) begin
          case (density)
            0: b = 8'($urandom) & 8'($urandom) & 8'($urandom);
            1: b = 8'($urandom) | 8'($urandom);
            default: b = 8'($urandom);
          endcase
        end else begin
          b = 8'($urandom);
        end
        send_byte(b, (k == 0) ? first_flag : 1'b0);
        sent++;
      end
      prev_full = (len == MESSAGE_BYTES_DEF);
    end
  endtask

  initial begin
    rst <= 1'b1;
    msg_valid <= 1'b0;
    msg_req <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_full_bitmap_message();
    test_other_message_type();
    test_result_backpressure();
    test_random_messages();
    msg_valid <= 1'b0;

    // drain, then idle on to catch any stray result
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d message bytes (%0d SI1 messages), checked %0d results, %0d ARFCNs.",
             bytes_sent, si1_messages, results_checked, arfcn_results);
    $display("Cell channel format codes reached (bit per code): %b", formats_seen);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
